// ===== rtl/gwwm_pkg.sv =====
// Shared types, constants and helper functions for the gapless wildcard window matcher.
// Has no dependencies. The cell and top-level files use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package gwwm_pkg;

    // Sizes
    localparam int MAX_QUERY = 64;
    localparam int QPOS_W    = $clog2(MAX_QUERY);
    localparam int LEN_W     = QPOS_W + 1;
    localparam int SYM_W     = 8;
    localparam int REQ_W     = 2;

    // Symbol codes
    localparam logic [SYM_W-1:0] SYM_WILD       = 8'h4E;
    localparam logic [SYM_W-1:0] SYM_WILD_LOWER = 8'h6E;
    localparam logic [SYM_W-1:0] SYM_GAP        = 8'h5F;

    // Request kinds carried on the input tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_BASE    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req_type;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // Control shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    // Clamp the configured length to the range 1 to MAX_QUERY.
    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (len > LEN_W'(MAX_QUERY)) begin
            res = LEN_W'(MAX_QUERY);
        end
        return res;
    endfunction

    function automatic logic is_wild(input logic [SYM_W-1:0] c);
        return (c == SYM_WILD) || (c == SYM_WILD_LOWER);
    endfunction

    // A position scores when both sides match or either side is a wildcard.
    function automatic logic sym_hit(input logic [SYM_W-1:0] b, input logic [SYM_W-1:0] q);
        return (b == q) || is_wild(b) || is_wild(q);
    endfunction

    function automatic logic [SYM_W-1:0] sym_out(input logic [SYM_W-1:0] b,
                                                 input logic [SYM_W-1:0] q);
        logic [SYM_W-1:0] res;
        if (b == q) begin
            res = b;
        end else if (is_wild(b) || is_wild(q)) begin
            res = SYM_WILD;
        end else begin
            res = SYM_GAP;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gwwm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Has no dependencies. Holds the query symbols of the matcher.
`timescale 1ns / 1ps
`default_nettype none

module gwwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/gwwm_cell.sv =====
// One cell of the base-symbol window chain: holds one symbol, takes its neighbor's on a shift.
// Depends on gwwm_pkg for the symbol width and the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module gwwm_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gwwm_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic [gwwm_pkg::SYM_W-1:0]     i_d,
    output logic      [gwwm_pkg::SYM_W-1:0]     o_q
);

    logic [gwwm_pkg::SYM_W-1:0] r_sym;

    // The window restarts empty, so a clear wins over a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_sym <= '0;
        end else if (i_ctrl.shift) begin
            r_sym <= i_d;
        end
    end

    assign o_q = r_sym;

endmodule

`default_nettype wire

// ===== rtl/gapless_wildcard_window_matcher_unit.sv =====
// Top level of the gapless wildcard window matcher: window cell chain, query RAM, sequencer.
// Depends on gwwm_pkg, gwwm_cell and gwwm_ram.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tuser: req_type; tdata: query_pos, symbol
//   m_axis    out        m_axis_tvalid/tready       tdata: out_symbol, window_score; tlast
//   cfg       in         i_cfg_we                   i_cfg_wdata: query_length
//
// Load, restart and base items that leave the window short are taken without a sweep.
// A base item that completes a window starts a sweep that takes no items: the window chain
// rotates through all 64 cells once, and a result leaves on each of the last query_length steps.
// A stalled output holds the rotation on a result step; the next item is taken while
// the final result still waits in the output register.
// Reset is synchronous and active low; it empties the window and sets query_length to 1.
`timescale 1ns / 1ps
`default_nettype none

module gapless_wildcard_window_matcher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,     // query_length
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // [5:0] query_pos, [13:6] symbol, [15:14] zero
    input  wire logic [1:0]  s_axis_tuser,    // [1:0] req_type
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,    // [7:0] out_symbol, [14:8] window_score, [15] zero
    output logic             m_axis_tlast     // last_of_window
);

    localparam int MAXQ   = gwwm_pkg::MAX_QUERY;
    localparam int QPOS_W = gwwm_pkg::QPOS_W;
    localparam int LEN_W  = gwwm_pkg::LEN_W;
    localparam int SYM_W  = gwwm_pkg::SYM_W;

    // Registers
    gwwm_pkg::t_state      r_state, n_state;
    logic [LEN_W-1:0]      r_qlen;
    logic [LEN_W-1:0]      r_fill, n_fill;
    logic [QPOS_W-1:0]     r_cnt, n_cnt;
    logic [LEN_W-1:0]      r_score, n_score;
    logic                  r_out_valid, n_out_valid;
    logic [SYM_W-1:0]      r_out_sym, n_out_sym;
    logic [LEN_W-1:0]      r_out_score, n_out_score;
    logic                  r_out_last, n_out_last;

    // Combinational signals
    gwwm_pkg::t_req_type   req;
    gwwm_pkg::t_cell_ctrl  cell_ctrl;
    logic                  in_acc;
    logic [QPOS_W-1:0]     in_pos;
    logic [SYM_W-1:0]      in_sym;
    logic [LEN_W-1:0]      len;
    logic [LEN_W-1:0]      fill_inc;
    logic [LEN_W-1:0]      pos_sum;
    logic                  emit;
    logic                  out_free;
    logic                  step;
    logic                  q_we;
    logic [QPOS_W-1:0]     q_raddr;
    logic [SYM_W-1:0]      q_sym;
    logic [SYM_W-1:0]      chain_in;
    logic [SYM_W-1:0]      cell_q [MAXQ];

    assign req    = gwwm_pkg::t_req_type'(s_axis_tuser);
    assign in_pos = s_axis_tdata[QPOS_W-1:0];
    assign in_sym = s_axis_tdata[QPOS_W +: SYM_W];
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign len    = gwwm_pkg::eff_length(r_qlen);

    assign s_axis_tready = (r_state == gwwm_pkg::ST_IDLE);

    // Query store: written by load items, read one step ahead of the sweep.
    assign q_we    = in_acc && (req == gwwm_pkg::REQ_LOAD);
    assign q_raddr = n_cnt + len[QPOS_W-1:0];

    gwwm_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAXQ)
    ) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (in_pos),
        .i_wdata (in_sym),
        .i_raddr (q_raddr),
        .o_rdata (q_sym)
    );

    // Window cell chain: cell 0 holds the oldest symbol. A base item shifts the new
    // symbol in at the top; a sweep step rotates cell 0 back to the top.
    assign chain_in = (r_state == gwwm_pkg::ST_IDLE) ? in_sym : cell_q[0];

    for (genvar k = 0; k < MAXQ; k++) begin : g_cell
        logic [SYM_W-1:0] cell_d;
        if (k == MAXQ - 1) begin : g_top
            assign cell_d = chain_in;
        end else begin : g_mid
            assign cell_d = cell_q[k+1];
        end

        gwwm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_d     (cell_d),
            .o_q     (cell_q[k])
        );
    end

    // Sweep step k yields a result once k + len reaches the cell count.
    assign pos_sum  = LEN_W'({1'b0, r_cnt}) + len;
    assign emit     = pos_sum[LEN_W-1];
    assign out_free = !r_out_valid || m_axis_tready;
    assign step     = (r_state == gwwm_pkg::ST_SWEEP) && (!emit || out_free);
    assign fill_inc = (r_fill < LEN_W'(MAXQ)) ? r_fill + LEN_W'(1) : r_fill;

    // Sequencer: next state, cell control and output register loads.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = '0;
        n_score     = r_score;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_sym   = r_out_sym;
        n_out_score = r_out_score;
        n_out_last  = r_out_last;
        cell_ctrl   = '0;

        unique case (r_state)
            gwwm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (req)
                        gwwm_pkg::REQ_BASE: begin
                            cell_ctrl.shift = 1'b1;
                            n_fill          = fill_inc;
                            if (fill_inc >= len) begin
                                n_state = gwwm_pkg::ST_SWEEP;
                                n_score = '0;
                            end
                        end
                        gwwm_pkg::REQ_RESTART: begin
                            cell_ctrl.clear = 1'b1;
                            n_fill          = '0;
                        end
                        default: begin
                            // Loads go to the query RAM; other codes are ignored.
                        end
                    endcase
                end
            end
            gwwm_pkg::ST_SWEEP: begin
                n_cnt = r_cnt;
                if (step) begin
                    cell_ctrl.shift = 1'b1;
                    n_cnt           = r_cnt + QPOS_W'(1);
                    if (emit) begin
                        n_score     = r_score + LEN_W'(gwwm_pkg::sym_hit(cell_q[0], q_sym));
                        n_out_valid = 1'b1;
                        n_out_sym   = gwwm_pkg::sym_out(cell_q[0], q_sym);
                        n_out_score = n_score;
                        n_out_last  = (r_cnt == QPOS_W'(MAXQ - 1));
                    end
                    if (r_cnt == QPOS_W'(MAXQ - 1)) begin
                        n_state = gwwm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = gwwm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gwwm_pkg::ST_IDLE;
            r_qlen      <= LEN_W'(1);
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_qlen <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_score     <= n_score;
        r_out_sym   <= n_out_sym;
        r_out_score <= n_out_score;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_score, r_out_sym};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== tb/tb_gapless_wildcard_window_matcher_unit.sv =====
// Self-checking testbench for the gapless wildcard window matcher: a scoreboard class predicts
// every window result, tasks drive the input and configuration ports with random pacing.
// Depends on gwwm_pkg and gapless_wildcard_window_matcher_unit.
`timescale 1ns / 1ps

module tb_gapless_wildcard_window_matcher_unit;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int NUM_PHASES     = 9;
    localparam int PRESSURE_PHASE = 3;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    // One expected result of a window position.
    typedef struct packed {
        logic [7:0] sym;
        logic [6:0] score;
        logic       last;
    } t_match_res;

    // Scoreboard: keeps its own copy of the query, the window and the length register,
    // and queues the results that each accepted item should produce.
    class match_scoreboard;
        logic [7:0]  query_mem [gwwm_pkg::MAX_QUERY];
        logic [7:0]  window [gwwm_pkg::MAX_QUERY];
        int unsigned fill;
        logic [6:0]  qlen_reg;
        t_match_res  pending [$];
        int          errors;

        function new();
            fill = 0;
            qlen_reg = 7'd1;
            errors = 0;
            foreach (window[i]) begin
                window[i] = '0;
                query_mem[i] = '0;
            end
        endfunction

        // Window width after clamping the register to 1..MAX_QUERY.
        function int unsigned eff_len();
            int unsigned n;
            n = qlen_reg;
            if (n == 0) begin
                n = 1;
            end else if (n > gwwm_pkg::MAX_QUERY) begin
                n = gwwm_pkg::MAX_QUERY;
            end
            return n;
        endfunction

        function void set_length(logic [6:0] v);
            qlen_reg = v;
        endfunction

        // Update the state for one accepted item and queue the window it completes.
        function void note_item(logic [1:0] req, logic [5:0] pos, logic [7:0] sym);
            int unsigned len;
            int unsigned base_off;
            int unsigned score;
            int unsigned i;
            logic [7:0] b;
            logic [7:0] q;
            t_match_res r;
            if (req == gwwm_pkg::REQ_LOAD) begin
                query_mem[pos] = sym;
            end else if (req == gwwm_pkg::REQ_RESTART) begin
                foreach (window[j]) begin
                    window[j] = '0;
                end
                fill = 0;
            end else if (req == gwwm_pkg::REQ_BASE) begin
                for (i = 0; i < gwwm_pkg::MAX_QUERY - 1; i++) begin
                    window[i] = window[i + 1];
                end
                window[gwwm_pkg::MAX_QUERY - 1] = sym;
                if (fill < gwwm_pkg::MAX_QUERY) begin
                    fill++;
                end
                len = eff_len();
                if (fill >= len) begin
                    base_off = gwwm_pkg::MAX_QUERY - len;
                    score = 0;
                    for (i = 0; i < len; i++) begin
                        b = window[base_off + i];
                        q = query_mem[i];
                        if (b == q) begin
                            r.sym = b;
                            score++;
                        end else if (b == gwwm_pkg::SYM_WILD ||
                                     b == gwwm_pkg::SYM_WILD_LOWER ||
                                     q == gwwm_pkg::SYM_WILD ||
                                     q == gwwm_pkg::SYM_WILD_LOWER) begin
                            r.sym = gwwm_pkg::SYM_WILD;
                            score++;
                        end else begin
                            r.sym = gwwm_pkg::SYM_GAP;
                        end
                        r.score = 7'(score);
                        r.last = (i == len - 1);
                        pending.push_back(r);
                    end
                end
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_match(logic [15:0] data, logic last);
            t_match_res want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h score %0d last %0b",
                         $time, data[7:0], data[14:8], last);
                return;
            end
            want = pending.pop_front();
            if (data[7:0] !== want.sym) begin
                errors++;
                $display("%0t: out_symbol expected %h actual %h", $time, want.sym, data[7:0]);
            end
            if (data[14:8] !== want.score) begin
                errors++;
                $display("%0t: window_score expected %0d actual %0d",
                         $time, want.score, data[14:8]);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_window expected %0b actual %0b", $time, want.last, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [5:0] query_pos, [13:6] symbol, [15:14] zero
    logic [1:0]  s_axis_tuser;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [7:0] out_symbol, [14:8] window_score, [15] zero
    logic        m_axis_tlast;   // last_of_window

    match_scoreboard sb;
    int              burst_left;
    bit [gwwm_pkg::MAX_QUERY-1:0] loaded;
    bit              hold_off_request;
    int unsigned     cycle_count = 0;

    gapless_wildcard_window_matcher_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_gapless_wildcard_window_matcher_unit: errors");
            $finish;
        end
    end

    // Check every result taken from the output stream.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_match(m_axis_tdata, m_axis_tlast);
        end
    end

    // Output side: stall pattern changes every span, with one long hold-off on request.
    initial begin
        int span;
        int mode;
        int step;
        bit rdy;
        forever begin
            span = $urandom_range(30, 250);
            mode = $urandom_range(0, 3);
            for (step = 0; step < span; step++) begin
                if (hold_off_request) begin
                    hold_off_request = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = (step % 5) != 4;
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
                m_axis_tready <= rdy;
                @(posedge i_clk);
            end
        end
    end

    // Symbols drawn mostly from a small alphabet so that matches and wildcards are common.
    function automatic logic [7:0] random_symbol();
        logic [7:0] s;
        case ($urandom_range(0, 19))
            0, 1, 2:    s = "A";
            3, 4, 5:    s = "C";
            6, 7, 8:    s = "G";
            9, 10, 11:  s = "T";
            12, 13:     s = gwwm_pkg::SYM_WILD;
            14:         s = gwwm_pkg::SYM_WILD_LOWER;
            default:    s = 8'($urandom);
        endcase
        return s;
    endfunction

    // Offer one item, wait for its handshake, then continue the burst or pause.
    task automatic send_item(input logic [1:0] req, input logic [5:0] pos,
                             input logic [7:0] sym);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, sym, pos};
        if (req == gwwm_pkg::REQ_LOAD) begin
            loaded[pos] = 1'b1;
        end
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(req, pos, sym);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                4, 5, 6:    gap = $urandom_range(1, 4);
                7, 8:       gap = $urandom_range(5, 30);
                default:    gap = $urandom_range(31, 90);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // A window only reads query positions below the current width, so fill those first.
    task automatic load_missing();
        int p;
        for (p = 0; p < sb.eff_len(); p++) begin
            if (!loaded[p]) begin
                send_item(gwwm_pkg::REQ_LOAD, 6'(p), random_symbol());
            end
        end
    endtask

    // Mostly base symbols; loads, restarts and ignored requests mixed in.
    task automatic random_item();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            send_item(gwwm_pkg::REQ_LOAD, 6'($urandom), random_symbol());
        end else if (roll < 14 && sb.eff_len() <= 16) begin
            send_item(gwwm_pkg::REQ_RESTART, 6'($urandom), 8'($urandom));
        end else if (roll < 18) begin
            send_item(REQ_IGNORED, 6'($urandom), 8'($urandom));
        end else begin
            load_missing();
            send_item(gwwm_pkg::REQ_BASE, 6'($urandom), random_symbol());
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle.
    task automatic drain_to_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [6:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_length(v);
        i_cfg_we    <= 1'b0;
    endtask

    // Length register per phase: zero, above the maximum, the maximum and small widths.
    function automatic logic [6:0] phase_length(input int idx);
        logic [6:0] v;
        case (idx)
            0: v = 7'd0;
            1: v = 7'd3;
            2: v = 7'd127;
            3: v = 7'd4;
            4: v = 7'd2;
            5: v = 7'd64;
            6: v = 7'd9;
            7: v = 7'd1;
            default: v = 7'd6;
        endcase
        return v;
    endfunction

    // Main sequence: reset, directed items, then one random phase per length setting.
    initial begin
        int p;
        int k;
        int n_items;
        logic [6:0] len_cfg;
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        loaded = '0;
        burst_left = 0;
        hold_off_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset width of one.
        send_item(gwwm_pkg::REQ_LOAD, 6'd0, "A");
        send_item(gwwm_pkg::REQ_BASE, 6'd0, "A");                      // plain match
        send_item(gwwm_pkg::REQ_BASE, 6'd0, gwwm_pkg::SYM_WILD);       // base-side wildcard
        send_item(gwwm_pkg::REQ_BASE, 6'd0, gwwm_pkg::SYM_WILD_LOWER); // lowercase base wildcard
        send_item(gwwm_pkg::REQ_BASE, 6'd0, "C");                      // mismatch
        send_item(gwwm_pkg::REQ_LOAD, 6'd0, gwwm_pkg::SYM_WILD_LOWER); // query-side wildcard
        send_item(gwwm_pkg::REQ_BASE, 6'd0, "G");
        send_item(gwwm_pkg::REQ_BASE, 6'd0, 8'hFF);
        send_item(gwwm_pkg::REQ_LOAD, 6'd63, 8'hFF);
        send_item(gwwm_pkg::REQ_LOAD, 6'd0, 8'h00);
        send_item(gwwm_pkg::REQ_BASE, 6'd63, 8'h00);                   // all-zero symbol match
        send_item(REQ_IGNORED, 6'd63, 8'hFF);                          // undefined request kind
        send_item(gwwm_pkg::REQ_RESTART, 6'd0, 8'h00);
        send_item(gwwm_pkg::REQ_LOAD, 6'd0, gwwm_pkg::SYM_WILD);
        send_item(gwwm_pkg::REQ_BASE, 6'd0, gwwm_pkg::SYM_WILD);       // both wildcard, equal
        send_item(gwwm_pkg::REQ_BASE, 6'd0, gwwm_pkg::SYM_WILD_LOWER); // both wildcard, mixed case

        // Random phases; some keep the window across the width change.
        for (p = 0; p < NUM_PHASES; p++) begin
            drain_to_idle();
            len_cfg = phase_length(p);
            write_length(len_cfg);
            if (sb.eff_len() <= 16 && $urandom_range(0, 1) == 1) begin
                send_item(gwwm_pkg::REQ_RESTART, 6'($urandom), 8'($urandom));
            end
            if (p == PRESSURE_PHASE) begin
                hold_off_request = 1'b1;
            end
            n_items = (sb.eff_len() > 16) ? 10 : 11;
            for (k = 0; k < n_items; k++) begin
                random_item();
            end
        end

        drain_to_idle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_gapless_wildcard_window_matcher_unit: clean");
        end else begin
            $display("tb_gapless_wildcard_window_matcher_unit: errors");
        end
        $finish;
    end

endmodule
